### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hdl/puc_pkg.sv
// ----------------------------------------------------------------------------
// puc_pkg
// Mode codes, escape phases, character constants and hex helpers.
// ----------------------------------------------------------------------------
package puc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_URL  = 2'd0;
  localparam mode_t MODE_PATH = 2'd1;
  localparam mode_t MODE_DEC  = 2'd2;

  localparam logic [1:0] ESC_IDLE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  localparam byte_t CH_0       = 8'h30;
  localparam byte_t CH_9       = 8'h39;
  localparam byte_t CH_UA      = 8'h41;
  localparam byte_t CH_UF      = 8'h46;
  localparam byte_t CH_UZ      = 8'h5A;
  localparam byte_t CH_LA      = 8'h61;
  localparam byte_t CH_LF      = 8'h66;
  localparam byte_t CH_LZ      = 8'h7A;
  localparam byte_t CH_DASH    = 8'h2D;
  localparam byte_t CH_UNDER   = 8'h5F;
  localparam byte_t CH_DOT     = 8'h2E;
  localparam byte_t CH_TILDE   = 8'h7E;
  localparam byte_t CH_SLASH   = 8'h2F;
  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_PLUS    = 8'h2B;
  localparam byte_t CH_PERCENT = 8'h25;

  localparam byte_t HEX_LETTER_OFS = 8'd55;
  localparam byte_t HEX_DIGIT_OFS  = 8'd48;

  function automatic byte_t hex_char(input logic [3:0] n);
    byte_t r;
    if (n > 4'd9) r = {4'd0, n} + HEX_LETTER_OFS;
    else          r = {4'd0, n} + HEX_DIGIT_OFS;
    return r;
  endfunction

  // bit 4 set when c is a hex digit, low bits hold its value
  function automatic logic [4:0] hex_value(input byte_t c);
    logic [4:0] v;
    v = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      v = {1'b1, c[3:0]};
    end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic logic passes(input byte_t c, input logic path);
    logic p;
    p = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
        (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_UNDER ||
        c == CH_DOT || c == CH_TILDE || (path && (c == CH_SLASH || c == CH_COLON));
    return p;
  endfunction

endpackage

### hdl/percent_url_codec.sv
// ----------------------------------------------------------------------------
// percent_url_codec
// Byte-stream percent codec: URL encode, path encode and decode.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_write_en/cfg_codec_mode set the mode (0 URL encode, 1 path encode,
//   2 or 3 decode); write it only while the block is idle.
//   Input requests (in_byte_in, in_is_last) are taken when in_valid is high
//   and in_stall low. Each request yields zero to three result requests on
//   the out_ channel, taken when out_valid is high and out_stall low.
//   Each request's results pass through the result buffer and then the output
//   register. Throughput: one request per cycle while each yields at most one
//   result and the receiver does not stall; an escaped byte in encode yields
//   three results and stalls the input until its last result moves out of the
//   buffer. The rate is set by the single output register draining the
//   three-entry result buffer, one entry per cycle unless the receiver stalls.
//   Reset clears the mode to URL encode, the escape state, the buffer and
//   the output register.
//   When the receiver stalls, the output holds its result and the buffer
//   holds the rest; the input is stalled once the buffer cannot drain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module percent_url_codec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_write_en,
  input  puc_pkg::mode_t     cfg_codec_mode,
  input  logic               in_valid,
  output logic               in_stall,
  input  puc_pkg::byte_t     in_byte_in,
  input  logic               in_is_last,
  output logic               out_valid,
  input  logic               out_stall,
  output puc_pkg::byte_t     out_byte_out,
  output logic               out_run_last,
  output logic               out_bad_escape,
  output logic               out_string_end
);
  import puc_pkg::*;

  mode_t      mode_r;
  logic [1:0] esc_phase_r, esc_phase_nxt;
  logic [3:0] high_nib_r, high_nib_nxt;

  byte_t      pend_byte_r [3];
  logic [1:0] pend_cnt_r;
  logic       pend_bad_r;
  logic       pend_end_r;

  logic       out_valid_r;
  byte_t      out_byte_r;
  logic       out_run_last_r, out_bad_r, out_end_r;

  byte_t      res_byte [3];
  logic [1:0] res_cnt;
  logic       res_bad;
  logic [4:0] hv;
  logic       encode;
  logic       out_load, pend_move, in_take;

  assign encode    = (mode_r == MODE_URL) || (mode_r == MODE_PATH);
  assign out_load  = !out_valid_r || !out_stall;
  assign pend_move = out_load && (pend_cnt_r != 2'd0);
  assign in_stall  = (pend_cnt_r != 2'd0) && !(pend_cnt_r == 2'd1 && out_load);
  assign in_take   = in_valid && !in_stall;

  always_comb begin
    hv            = hex_value(in_byte_in);
    res_byte[0]   = in_byte_in;
    res_byte[1]   = hex_char(in_byte_in[7:4]);
    res_byte[2]   = hex_char(in_byte_in[3:0]);
    res_cnt       = 2'd0;
    res_bad       = 1'b0;
    esc_phase_nxt = ESC_IDLE;
    high_nib_nxt  = 4'd0;
    if (encode) begin
      res_cnt = 2'd1;
      if (passes(in_byte_in, mode_r == MODE_PATH)) begin
        res_byte[0] = in_byte_in;
      end else if (in_byte_in == CH_SPACE) begin
        res_byte[0] = CH_PLUS;
      end else begin
        res_byte[0] = CH_PERCENT;
        res_cnt     = 2'd3;
      end
    end else begin
      esc_phase_nxt = esc_phase_r;
      high_nib_nxt  = high_nib_r;
      if (esc_phase_r == ESC_IDLE) begin
        if (in_byte_in == CH_PERCENT) begin
          esc_phase_nxt = ESC_HIGH;
        end else begin
          res_cnt     = 2'd1;
          res_byte[0] = (in_byte_in == CH_PLUS) ? CH_SPACE : in_byte_in;
        end
      end else if (!hv[4]) begin
        res_cnt       = 2'd1;
        res_bad       = 1'b1;
        res_byte[0]   = 8'd0;
        esc_phase_nxt = ESC_IDLE;
        high_nib_nxt  = 4'd0;
      end else if (esc_phase_r == ESC_HIGH) begin
        high_nib_nxt  = hv[3:0];
        esc_phase_nxt = ESC_LOW;
      end else begin
        res_cnt       = 2'd1;
        res_byte[0]   = {high_nib_r, hv[3:0]};
        esc_phase_nxt = ESC_IDLE;
        high_nib_nxt  = 4'd0;
      end
      if (in_is_last && esc_phase_nxt != ESC_IDLE) begin
        res_cnt     = 2'd1;
        res_bad     = 1'b1;
        res_byte[0] = 8'd0;
      end
      if (in_is_last) begin
        esc_phase_nxt = ESC_IDLE;
        high_nib_nxt  = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_URL;
      esc_phase_r <= ESC_IDLE;
      high_nib_r  <= 4'd0;
      pend_cnt_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        mode_r <= cfg_codec_mode;
      end
      if (in_take) begin
        esc_phase_r <= esc_phase_nxt;
        high_nib_r  <= high_nib_nxt;
        pend_cnt_r  <= res_cnt;
      end else if (pend_move) begin
        pend_cnt_r <= pend_cnt_r - 2'd1;
      end
      if (out_load) begin
        out_valid_r <= pend_cnt_r != 2'd0;
      end
    end
  end

  // load the buffer on accept, advance it as the head moves out
  always_ff @(posedge clk) begin
    if (in_take) begin
      pend_byte_r <= res_byte;
      pend_bad_r  <= res_bad;
      pend_end_r  <= in_is_last;
    end else if (pend_move) begin
      pend_byte_r[0] <= pend_byte_r[1];
      pend_byte_r[1] <= pend_byte_r[2];
    end
    if (pend_move) begin
      out_byte_r     <= pend_byte_r[0];
      out_bad_r      <= pend_bad_r;
      out_run_last_r <= pend_cnt_r == 2'd1;
      out_end_r      <= (pend_cnt_r == 2'd1) && pend_end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte_out   = out_byte_r;
  assign out_run_last   = out_run_last_r;
  assign out_bad_escape = out_bad_r;
  assign out_string_end = out_end_r;

  `ASSERT_IMPL(a_take_drains, clk, rst_n, in_take && pend_cnt_r != 2'd0, pend_cnt_r == 2'd1 && out_load)
  `ASSERT_IMPL(a_phase_legal, clk, rst_n, 1'b1, esc_phase_r != 2'd3)
  `ASSERT_IMPL(a_bad_single, clk, rst_n, out_valid_r && out_bad_r, out_run_last_r && out_byte_r == 8'd0)
  `ASSERT_IMPL(a_end_on_last, clk, rst_n, out_valid_r && out_end_r, out_run_last_r)
  `ASSERT_NEXT(a_last_clears, clk, rst_n, in_take && in_is_last, esc_phase_r == ESC_IDLE)

endmodule

### dv/percent_url_codec_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percent_url_codec_tb
// Checks the percent codec in URL encode, path encode and both decode codes.
// A directed opening covers byte extremes, the pass-through marks, escapes,
// bad digits, escapes cut short and mode changes with an escape open. It is
// followed by random strings in every mode. Each accepted input request is
// run through a local model of the codec. Result requests are compared field
// by field, in order, against the bytes that model predicts. Both sides idle
// at random, and the receiver holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module percent_url_codec_tb;
  import puc_pkg::*;

  localparam mode_t MODE_DEC_ALT = 2'd3;
  localparam int    SETTLE_CYCLES = 6;
  localparam int    QUIET_LIMIT   = 1000;
  localparam int    SQUEEZE_LEN   = 80;

  typedef struct packed {
    byte_t c;
    logic  last;
  } char_req_t;

  typedef struct packed {
    byte_t b;
    logic  run_last;
    logic  bad;
    logic  fin;
  } coded_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_write_en = 1'b0;
  mode_t cfg_codec_mode = MODE_URL;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t in_byte_in = 8'h00;
  logic  in_is_last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  byte_t out_byte_out;
  logic  out_run_last;
  logic  out_bad_escape;
  logic  out_string_end;

  char_req_t text_q[$];
  coded_t    coded_q[$];

  mode_t      pred_mode = MODE_URL;
  logic [1:0] pred_phase = ESC_IDLE;
  logic [3:0] pred_high = 4'd0;

  int queued_cnt = 0;
  int taken_cnt = 0;
  int got_cnt = 0;
  int err_cnt = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  int squeeze_left = 0;
  bit squeeze_done = 1'b0;
  int quiet_cnt = 0;
  char_req_t next_req;
  coded_t    head;

  percent_url_codec uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_codec_mode (cfg_codec_mode),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte_in     (in_byte_in),
    .in_is_last     (in_is_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte_out   (out_byte_out),
    .out_run_last   (out_run_last),
    .out_bad_escape (out_bad_escape),
    .out_string_end (out_string_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic byte_t nib_ascii(input logic [3:0] n);
    if (n > 4'd9) return {4'd0, n} + HEX_LETTER_OFS;
    return {4'd0, n} + HEX_DIGIT_OFS;
  endfunction

  function automatic logic [4:0] digit_of(input byte_t c);
    byte_t d;
    d = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic is_plain(input byte_t c, input logic path);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
           (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_UNDER ||
           c == CH_DOT || c == CH_TILDE ||
           (path && (c == CH_SLASH || c == CH_COLON));
  endfunction

  function automatic coded_t mk(input byte_t b, input logic bad);
    coded_t r;
    r.b = b;
    r.run_last = 1'b0;
    r.bad = bad;
    r.fin = 1'b0;
    return r;
  endfunction

  function automatic void codec_predict(input byte_t c, input logic last);
    coded_t     r[$];
    logic [4:0] dv;
    if (pred_mode < MODE_DEC) begin
      pred_phase = ESC_IDLE;
      pred_high = 4'd0;
      if (is_plain(c, pred_mode == MODE_PATH)) begin
        r.push_back(mk(c, 1'b0));
      end else if (c == CH_SPACE) begin
        r.push_back(mk(CH_PLUS, 1'b0));
      end else begin
        r.push_back(mk(CH_PERCENT, 1'b0));
        r.push_back(mk(nib_ascii(c[7:4]), 1'b0));
        r.push_back(mk(nib_ascii(c[3:0]), 1'b0));
      end
    end else begin
      if (pred_phase == ESC_IDLE) begin
        if (c == CH_PERCENT) pred_phase = ESC_HIGH;
        else if (c == CH_PLUS) r.push_back(mk(CH_SPACE, 1'b0));
        else r.push_back(mk(c, 1'b0));
      end else begin
        dv = digit_of(c);
        if (!dv[4]) begin
          r.push_back(mk(8'h00, 1'b1));
          pred_phase = ESC_IDLE;
          pred_high = 4'd0;
        end else if (pred_phase == ESC_HIGH) begin
          pred_high = dv[3:0];
          pred_phase = ESC_LOW;
        end else begin
          r.push_back(mk({pred_high, dv[3:0]}, 1'b0));
          pred_phase = ESC_IDLE;
          pred_high = 4'd0;
        end
      end
      if (last && pred_phase != ESC_IDLE) r.push_back(mk(8'h00, 1'b1));
      if (last) begin
        pred_phase = ESC_IDLE;
        pred_high = 4'd0;
      end
    end
    if (r.size() > 0) begin
      r[r.size() - 1].run_last = 1'b1;
      r[r.size() - 1].fin = last;
    end
    foreach (r[i]) coded_q.push_back(r[i]);
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic byte_t rand_hex_char();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 4'd10) return CH_0 + v;
    if ($urandom_range(0, 1)) return CH_UA + v - 8'd10;
    return CH_LA + v - 8'd10;
  endfunction

  function automatic byte_t rand_non_hex();
    byte_t c;
    do c = byte_t'($urandom_range(0, 255)); while (digit_of(c) != 5'd0);
    return c;
  endfunction

  function automatic byte_t rand_text_byte();
    byte_t marks[9];
    int    r;
    marks = '{CH_SPACE, CH_SLASH, CH_COLON, CH_DASH, CH_UNDER, CH_DOT,
              CH_TILDE, CH_PERCENT, CH_PLUS};
    r = $urandom_range(0, 99);
    if (r < 40) return byte_t'($urandom_range(0, 255));
    if (r < 70) return byte_t'($urandom_range(CH_0, CH_LZ));
    return marks[$urandom_range(0, 8)];
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s at result %0d: got 0x%0h, want 0x%0h", what, got_cnt, got, want);
    err_cnt++;
  endtask

  task automatic queue_byte(input byte_t c, input logic last);
    char_req_t q;
    q.c = c;
    q.last = last;
    text_q.push_back(q);
    queued_cnt++;
  endtask

  task automatic queue_string(input mode_t m);
    byte_t s[$];
    int    n;
    int    r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
    if (m >= MODE_DEC) begin
      while (s.size() < n) begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          s.push_back(CH_PERCENT);
          s.push_back(rand_hex_char());
          s.push_back(rand_hex_char());
        end else if (r < 45) begin
          s.push_back(CH_PLUS);
        end else if (r < 50) begin
          s.push_back(CH_PERCENT);
          if ($urandom_range(0, 1)) s.push_back(rand_hex_char());
          s.push_back(rand_non_hex());
        end else begin
          s.push_back(rand_text_byte());
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        s.push_back(CH_PERCENT);
        if ($urandom_range(0, 1)) s.push_back(rand_hex_char());
      end
    end else begin
      repeat (n) s.push_back(rand_text_byte());
    end
    foreach (s[i]) queue_byte(s[i], i == s.size() - 1);
  endtask

  task automatic settle();
    while (taken_cnt != queued_cnt || coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_codec_mode <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    pred_mode = m;
  endtask

  task automatic run_phase(input mode_t m, input int target);
    int start;
    settle();
    write_mode(m);
    start = queued_cnt;
    while (queued_cnt - start < target) queue_string(m);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_in <= 8'h00;
      in_is_last <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        codec_predict(in_byte_in, in_is_last);
        taken_cnt++;
        tx_gap = idle_len(tx_calm);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          next_req = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte_in <= next_req.c;
          in_is_last <= next_req.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (coded_q.size() == 0) begin
          flag_mismatch("unexpected result", out_byte_out, 0);
        end else begin
          head = coded_q.pop_front();
          if (out_byte_out !== head.b) flag_mismatch("byte_out", out_byte_out, head.b);
          if (out_run_last !== head.run_last)
            flag_mismatch("run_last", out_run_last, head.run_last);
          if (out_bad_escape !== head.bad) flag_mismatch("bad_escape", out_bad_escape, head.bad);
          if (out_string_end !== head.fin) flag_mismatch("string_end", out_string_end, head.fin);
        end
        got_cnt++;
      end
      // hold off once for a long stretch so the input backs up
      if (squeeze_left > 0) begin
        squeeze_left--;
        out_stall <= 1'b1;
      end else if (!squeeze_done && got_cnt >= 150 && text_q.size() > 20) begin
        squeeze_done = 1'b1;
        squeeze_left = SQUEEZE_LEN - 1;
        out_stall <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else begin
        rx_hold = idle_len(rx_calm);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cnt = 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cnt = 0;
    end else begin
      quiet_cnt++;
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_URL);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_UA, 1'b0);
    queue_byte(CH_LZ, 1'b0);
    queue_byte(CH_TILDE, 1'b0);
    queue_byte(CH_SPACE, 1'b0);
    queue_byte(CH_SLASH, 1'b1);
    settle();
    write_mode(MODE_PATH);
    queue_byte(CH_SLASH, 1'b0);
    queue_byte(CH_COLON, 1'b0);
    queue_byte(CH_PERCENT, 1'b1);
    settle();
    write_mode(MODE_DEC_ALT);
    queue_byte(CH_PERCENT, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h61, 1'b0);
    queue_byte(CH_PLUS, 1'b0);
    queue_byte(8'h51, 1'b0);
    queue_byte(CH_PERCENT, 1'b0);
    queue_byte(8'h47, 1'b0);
    queue_byte(CH_PERCENT, 1'b0);
    queue_byte(8'h32, 1'b1);
    queue_byte(CH_PERCENT, 1'b1);
    // leave an escape open across a mode write
    queue_byte(CH_PERCENT, 1'b0);
    queue_byte(8'h34, 1'b0);
    settle();
    write_mode(MODE_DEC);
    queue_byte(8'h31, 1'b1);
    queue_byte(CH_PERCENT, 1'b0);
    settle();
    write_mode(MODE_URL);
    queue_byte(8'h78, 1'b0);
    settle();
    write_mode(MODE_DEC);
    queue_byte(8'h31, 1'b1);

    run_phase(MODE_URL, 55);
    run_phase(MODE_DEC, 60);
    run_phase(MODE_PATH, 55);
    run_phase(MODE_DEC_ALT, 50);
    run_phase(MODE_DEC, 60);
    run_phase(MODE_URL, 50);
    settle();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### percent_url_codec.f
+incdir+hdl
hdl/puc_pkg.sv
hdl/percent_url_codec.sv
dv/percent_url_codec_tb.sv
